/* design/qrot_pkg.sv */
// ----------------------------------------------------------------------------
// Quaternion rotation package
// Widths and constants shared by the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qrot_pkg;

    // Field widths.
    localparam int QUAT_W = 16;   // Q1.14 quaternion component
    localparam int VEC_W  = 16;   // input vector component
    localparam int ROT_W  = 18;   // saturated output component
    localparam int FRAC_W = 14;   // fraction bits of the quaternion

    // First product: 16x16 terms, three of them summed.
    localparam int P1_W   = QUAT_W + VEC_W;          // 32
    localparam int S1_W   = P1_W + 1;                // 33
    localparam int T_W    = S1_W - FRAC_W;           // 19

    // Second product: 19x16 terms, four of them summed.
    localparam int P2_W   = T_W + QUAT_W;            // 35
    localparam int S2_W   = P2_W + 2;                // 37
    localparam int R_W    = S2_W - FRAC_W;           // 23

    // Stream packing.
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    // Configuration register indexes.
    localparam logic [1:0] REG_QUAT_X = 2'd0;
    localparam logic [1:0] REG_QUAT_Y = 2'd1;
    localparam logic [1:0] REG_QUAT_Z = 2'd2;
    localparam logic [1:0] REG_QUAT_W = 2'd3;

    localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;

    localparam logic signed [ROT_W-1:0] ROT_MAX = 18'sd131071;
    localparam logic signed [ROT_W-1:0] ROT_MIN = -18'sd131072;

    // Rounding offset: one half in Q.14.
    localparam int HALF = 1 << (FRAC_W - 1);

    typedef logic signed [T_W-1:0] t_tcomp;
    typedef logic signed [R_W-1:0] t_rcomp;

endpackage

/* design/rotate_vector_by_quaternion.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotation
// Rotates a stream of 3D vectors by r = q * (v,0) * conj(q) in fixed point.
// ----------------------------------------------------------------------------
// The block accepts one vector per clock while the output is not stalled and
// returns the rotated vectors one result per transfer and in order. It is built
// as a five-stage pipeline: the twelve products of q by v, the sums that form the
// rounded intermediate quaternion t, the twelve products of t by conj(q), the
// rounded sums of the output, and the 18-bit saturation. Every stage holds a
// valid bit, and a stage takes new data whenever it is empty or its successor
// takes its data, so a stall on the output side only freezes the full stages
// and nothing is dropped or repeated. The quaternion sits in four registers
// written through the configuration port; it should be written only while no
// vector is in flight. After reset the quaternion is the identity rotation.
// ----------------------------------------------------------------------------
module rotate_vector_by_quaternion (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_idx,
    input  logic [qrot_pkg::QUAT_W-1:0]           i_cfg_data,
    // Input stream.
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata: vec_x [15:0], vec_y [31:16], vec_z [47:32]
    input  logic [qrot_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // Output stream.
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // tdata: rot_x [17:0], rot_y [35:18], rot_z [53:36], zero [55:54]
    output logic [qrot_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    // tuser: clipped [0]
    output logic                                  o_m_tuser
);
    import qrot_pkg::*;

    localparam int NSTG = 5;

    // Quaternion registers.
    logic signed [QUAT_W-1:0] r_qx, r_qy, r_qz, r_qw;

    // Pipeline control: one valid bit per stage, and the load enable of each.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_ld;

    // Stage data.
    logic signed [P1_W-1:0] r_p1 [12];
    t_tcomp                 r_tx, r_ty, r_tz, r_tw;
    logic signed [P2_W-1:0] r_p2 [12];
    t_rcomp                 r_rx, r_ry, r_rz;
    logic signed [ROT_W-1:0] r_ox, r_oy, r_oz;
    logic                   r_clip;

    // Combinational next values.
    logic signed [VEC_W-1:0] n_vx, n_vy, n_vz;
    logic signed [S1_W-1:0]  n_sx, n_sy, n_sz, n_sw;
    logic signed [S2_W-1:0]  n_ux, n_uy, n_uz;
    logic signed [ROT_W-1:0] n_ox, n_oy, n_oz;
    logic                    n_cx, n_cy, n_cz;

    // ------------------------------------------------------------------------
    // Configuration registers. Indexes above the four registers cannot occur
    // with a two-bit index.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
            r_qw <= QUAT_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_QUAT_X: r_qx <= i_cfg_data;
                REG_QUAT_Y: r_qy <= i_cfg_data;
                REG_QUAT_Z: r_qz <= i_cfg_data;
                REG_QUAT_W: r_qw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Flow control. A stage loads when it is empty or the stage after it is
    // loading; the last stage loads when its result has been taken.
    // ------------------------------------------------------------------------
    always_comb begin
        w_ld[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    assign o_s_tready = w_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: the twelve products of q by the input vector.
    // ------------------------------------------------------------------------
    assign n_vx = i_s_tdata[15:0];
    assign n_vy = i_s_tdata[31:16];
    assign n_vz = i_s_tdata[47:32];

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            // t.x terms
            r_p1[0]  <= P1_W'(r_qw) * P1_W'(n_vx);
            r_p1[1]  <= P1_W'(r_qy) * P1_W'(n_vz);
            r_p1[2]  <= P1_W'(r_qz) * P1_W'(n_vy);
            // t.y terms
            r_p1[3]  <= P1_W'(r_qw) * P1_W'(n_vy);
            r_p1[4]  <= P1_W'(r_qz) * P1_W'(n_vx);
            r_p1[5]  <= P1_W'(r_qx) * P1_W'(n_vz);
            // t.z terms
            r_p1[6]  <= P1_W'(r_qw) * P1_W'(n_vz);
            r_p1[7]  <= P1_W'(r_qx) * P1_W'(n_vy);
            r_p1[8]  <= P1_W'(r_qy) * P1_W'(n_vx);
            // t.w terms
            r_p1[9]  <= P1_W'(r_qx) * P1_W'(n_vx);
            r_p1[10] <= P1_W'(r_qy) * P1_W'(n_vy);
            r_p1[11] <= P1_W'(r_qz) * P1_W'(n_vz);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: sum and round to integers. The half is added before the
    // arithmetic shift, which gives round to nearest with ties upward.
    // ------------------------------------------------------------------------
    always_comb begin
        n_sx = S1_W'(r_p1[0]) + S1_W'(r_p1[1]) - S1_W'(r_p1[2]) + S1_W'(HALF);
        n_sy = S1_W'(r_p1[3]) + S1_W'(r_p1[4]) - S1_W'(r_p1[5]) + S1_W'(HALF);
        n_sz = S1_W'(r_p1[6]) + S1_W'(r_p1[7]) - S1_W'(r_p1[8]) + S1_W'(HALF);
        n_sw = S1_W'(HALF) - S1_W'(r_p1[9]) - S1_W'(r_p1[10]) - S1_W'(r_p1[11]);
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r_tx <= n_sx[S1_W-1:FRAC_W];
            r_ty <= n_sy[S1_W-1:FRAC_W];
            r_tz <= n_sz[S1_W-1:FRAC_W];
            r_tw <= n_sw[S1_W-1:FRAC_W];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: the twelve products of t by conj(q).
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_ld[2]) begin
            // r.x terms
            r_p2[0]  <= P2_W'(r_tx) * P2_W'(r_qw);
            r_p2[1]  <= P2_W'(r_tw) * P2_W'(r_qx);
            r_p2[2]  <= P2_W'(r_ty) * P2_W'(r_qz);
            r_p2[3]  <= P2_W'(r_tz) * P2_W'(r_qy);
            // r.y terms
            r_p2[4]  <= P2_W'(r_ty) * P2_W'(r_qw);
            r_p2[5]  <= P2_W'(r_tw) * P2_W'(r_qy);
            r_p2[6]  <= P2_W'(r_tz) * P2_W'(r_qx);
            r_p2[7]  <= P2_W'(r_tx) * P2_W'(r_qz);
            // r.z terms
            r_p2[8]  <= P2_W'(r_tz) * P2_W'(r_qw);
            r_p2[9]  <= P2_W'(r_tw) * P2_W'(r_qz);
            r_p2[10] <= P2_W'(r_tx) * P2_W'(r_qy);
            r_p2[11] <= P2_W'(r_ty) * P2_W'(r_qx);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: sum and round the output components at full width.
    // ------------------------------------------------------------------------
    always_comb begin
        n_ux = S2_W'(r_p2[0]) - S2_W'(r_p2[1]) - S2_W'(r_p2[2]) + S2_W'(r_p2[3])
             + S2_W'(HALF);
        n_uy = S2_W'(r_p2[4]) - S2_W'(r_p2[5]) - S2_W'(r_p2[6]) + S2_W'(r_p2[7])
             + S2_W'(HALF);
        n_uz = S2_W'(r_p2[8]) - S2_W'(r_p2[9]) - S2_W'(r_p2[10]) + S2_W'(r_p2[11])
             + S2_W'(HALF);
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[3]) begin
            r_rx <= n_ux[S2_W-1:FRAC_W];
            r_ry <= n_uy[S2_W-1:FRAC_W];
            r_rz <= n_uz[S2_W-1:FRAC_W];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: clamp each component to 18 bits and flag any clamping.
    // ------------------------------------------------------------------------
    always_comb begin
        n_cx = 1'b1;
        n_cy = 1'b1;
        n_cz = 1'b1;
        if (r_rx > R_W'(ROT_MAX)) begin
            n_ox = ROT_MAX;
        end else if (r_rx < R_W'(ROT_MIN)) begin
            n_ox = ROT_MIN;
        end else begin
            n_ox = r_rx[ROT_W-1:0];
            n_cx = 1'b0;
        end
        if (r_ry > R_W'(ROT_MAX)) begin
            n_oy = ROT_MAX;
        end else if (r_ry < R_W'(ROT_MIN)) begin
            n_oy = ROT_MIN;
        end else begin
            n_oy = r_ry[ROT_W-1:0];
            n_cy = 1'b0;
        end
        if (r_rz > R_W'(ROT_MAX)) begin
            n_oz = ROT_MAX;
        end else if (r_rz < R_W'(ROT_MIN)) begin
            n_oz = ROT_MIN;
        end else begin
            n_oz = r_rz[ROT_W-1:0];
            n_cz = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[4]) begin
            r_ox   <= n_ox;
            r_oy   <= n_oy;
            r_oz   <= n_oz;
            r_clip <= n_cx | n_cy | n_cz;
        end
    end

    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {2'b00, r_oz, r_oy, r_ox};
    assign o_m_tuser  = r_clip;

endmodule
